FILE: design/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared types, constants and register indexes of the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned MaxProcsDefault  = 16;
  localparam int unsigned MaxLevelsDefault = 4;
  localparam int unsigned TimeW            = 24;

  // Configuration register indexes.
  localparam logic [2:0] RegLevelsUsed = 3'd0;
  localparam logic [2:0] RegSlice0     = 3'd1;
  localparam logic [2:0] RegSlice1     = 3'd2;
  localparam logic [2:0] RegSlice2     = 3'd3;
  localparam logic [2:0] RegSlice3     = 3'd4;

  // Input item kinds.
  localparam logic KindArrive = 1'b0;
  localparam logic KindTick   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  proc_id;
    logic [15:0] work_time;
  } in_item_t;

  typedef struct packed {
    logic        ran;
    logic [3:0]  ran_pid;
    logic        first_run;
    logic        finished;
    logic [23:0] finish_time;
    logic [1:0]  level_after;
    logic        rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StProc,
    StPush,
    StOut
  } state_e;

endpackage

FILE: design/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler
// Arrivals enqueue at level 0 (or are rejected when it is full); ticks run the head of the lowest-numbered busy level.
// ----------------------------------------------------------------------------
// One item is in flight at a time, and the input is stalled until the block
// is back in idle. An arrival or an idle tick goes from idle straight to the
// output state; a tick that runs a process passes through the read and
// process states first, and through the push state as well when it requeues
// the process. The queue memory and the process memories each have one
// synchronous read port: the head id is read first, then the process
// record, then the record and any requeue are written back. A held result
// stalls the next beat until it is taken.
module multilevel_feedback_queue_scheduler #(
  parameter int unsigned MAX_PROCS  = mlfq_pkg::MaxProcsDefault,
  parameter int unsigned MAX_LEVELS = mlfq_pkg::MaxLevelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlfq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlfq_pkg::out_item_t out_data_o
);

  localparam int unsigned PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned AW = PW + LW;

  // Configuration registers.
  logic [2:0] levels_used_q;
  logic [7:0] slice_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_used_q <= 3'd4;
      slice_q[0] <= 8'd1;
      slice_q[1] <= 8'd2;
      slice_q[2] <= 8'd4;
      slice_q[3] <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mlfq_pkg::RegLevelsUsed: levels_used_q <= cfg_data_i[2:0];
        mlfq_pkg::RegSlice0:     slice_q[0] <= cfg_data_i;
        mlfq_pkg::RegSlice1:     slice_q[1] <= cfg_data_i;
        mlfq_pkg::RegSlice2:     slice_q[2] <= cfg_data_i;
        mlfq_pkg::RegSlice3:     slice_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] slice_of(input logic [LW-1:0] lv, input logic [7:0] s0,
                                          input logic [7:0] s1, input logic [7:0] s2,
                                          input logic [7:0] s3);
    logic [31:0] l;
    l = 32'(lv);
    if (l == 0) return s0;
    else if (l == 1) return s1;
    else if (l == 2) return s2;
    else return s3;
  endfunction

  // Reduces an incoming process id into the process range.
  function automatic logic [PW-1:0] pid_reduce(input logic [3:0] id);
    logic [4:0] r;
    r = {1'b0, id};
    for (int k = 0; k < 8; k++) begin
      if (32'(r) >= MAX_PROCS) r = r - 5'(MAX_PROCS);
    end
    return PW'(r);
  endfunction

  // Wraps a head plus count sum into a queue slot.
  function automatic logic [PW-1:0] slot_wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = s;
    if (32'(s) >= MAX_PROCS) r = s - (CW+1)'(MAX_PROCS);
    return PW'(r);
  endfunction

  // Memories: queue ids, and process records (work, slice).
  logic [PW-1:0] fifo_mem [MAX_LEVELS*MAX_PROCS];
  logic [15:0]   work_mem [MAX_PROCS];
  logic [7:0]    slc_mem  [MAX_PROCS];
  logic          fifo_we, proc_we;
  logic [AW-1:0] fifo_waddr, fifo_raddr;
  logic [PW-1:0] fifo_wdata, fifo_rdata_q, proc_addr;
  logic [15:0]   work_wdata, work_rdata_q;
  logic [7:0]    slc_wdata, slc_rdata_q;

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    fifo_rdata_q <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (proc_we) begin
      work_mem[proc_addr] <= work_wdata;
      slc_mem[proc_addr]  <= slc_wdata;
    end
    work_rdata_q <= work_mem[proc_addr];
    slc_rdata_q  <= slc_mem[proc_addr];
  end

  // Control state.
  mlfq_pkg::state_e state_q, state_d;
  logic [PW-1:0] head_q [MAX_LEVELS];
  logic [CW-1:0] count_q [MAX_LEVELS];
  logic [MAX_PROCS-1:0] started_q;
  logic [23:0] now_q;
  logic out_valid_q;
  mlfq_pkg::out_item_t out_q, out_d;
  logic [LW-1:0] lv_q, lv_d, tgt_q, tgt_d;
  logic [PW-1:0] pid_q, pid_d;
  logic busy_any;
  logic [LW-1:0] busy_lv;
  logic next_room;

  // Priority search over the level counts.
  always_comb begin
    busy_any = 1'b0;
    busy_lv  = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        busy_any = 1'b1;
        busy_lv  = LW'(i);
      end
    end
  end

  // Room check on the level below the running one.
  always_comb begin
    next_room = 1'b0;
    for (int i = 1; i < MAX_LEVELS; i++) begin
      if (LW'(i - 1) == lv_q && 32'(count_q[i]) < MAX_PROCS) next_room = 1'b1;
    end
  end

  logic accept;
  assign in_stall_o  = (state_q != mlfq_pkg::StIdle) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic [PW-1:0] arr_pid;
  logic [2:0] used;
  logic [31:0] used_n;
  logic head_pop, push_en, tail_push, time_step, start_set;
  logic [LW-1:0] push_lv;
  logic fin, expired;
  logic [CW:0] tail_sum;

  assign arr_pid = pid_reduce(in_data_i.proc_id);
  assign used    = (levels_used_q == 3'd0) ? 3'd1 :
                   (32'(levels_used_q) > MAX_LEVELS) ? 3'(MAX_LEVELS) : levels_used_q;
  assign used_n  = 32'(used);
  assign fin     = work_rdata_q <= 16'd1;
  // Slices of zero act as one tick: the expiry compare treats 0 as expired.
  assign expired = slc_rdata_q <= 8'd1;

  // Sequencer: arrivals are written directly; running ticks read, modify and write back.
  always_comb begin
    state_d = state_q;
    out_d = out_q;
    lv_d = lv_q;
    tgt_d = tgt_q;
    pid_d = pid_q;
    fifo_we = 1'b0;
    fifo_waddr = '0;
    fifo_wdata = pid_q;
    fifo_raddr = {busy_lv, head_q[busy_lv]};
    proc_we = 1'b0;
    proc_addr = pid_q;
    work_wdata = work_rdata_q;
    slc_wdata = slc_rdata_q;
    head_pop = 1'b0;
    tail_push = 1'b0;
    push_lv = lv_q;
    push_en = 1'b0;
    time_step = 1'b0;
    start_set = 1'b0;
    tail_sum = '0;
    case (state_q)
      mlfq_pkg::StIdle: begin
        if (accept) begin
          out_d = '0;
          if (in_data_i.kind == mlfq_pkg::KindArrive) begin
            if (32'(count_q[0]) >= MAX_PROCS) begin
              out_d.rejected = 1'b1;
              state_d = mlfq_pkg::StOut;
            end else begin
              tail_sum = (CW+1)'(head_q[0]) + (CW+1)'(count_q[0]);
              fifo_we = 1'b1;
              fifo_waddr = {LW'(0), slot_wrap(tail_sum)};
              fifo_wdata = arr_pid;
              proc_we = 1'b1;
              proc_addr = arr_pid;
              work_wdata = in_data_i.work_time;
              slc_wdata = slice_q[0];
              push_lv = '0;
              tail_push = 1'b1;
              state_d = mlfq_pkg::StOut;
            end
          end else if (!busy_any) begin
            time_step = 1'b1;
            state_d = mlfq_pkg::StOut;
          end else begin
            lv_d = busy_lv;
            state_d = mlfq_pkg::StRead;
          end
        end
      end
      mlfq_pkg::StRead: begin
        pid_d = fifo_rdata_q;
        proc_addr = pid_d;
        state_d = mlfq_pkg::StProc;
      end
      mlfq_pkg::StProc: begin
        out_d.ran = 1'b1;
        out_d.ran_pid = 4'(pid_q);
        out_d.first_run = !started_q[pid_q];
        start_set = 1'b1;
        time_step = 1'b1;
        proc_we = 1'b1;
        work_wdata = fin ? 16'd0 : work_rdata_q - 16'd1;
        tgt_d = lv_q;
        state_d = mlfq_pkg::StOut;
        if (fin) begin
          head_pop = 1'b1;
          out_d.finished = 1'b1;
          out_d.finish_time = now_q + 24'd1;
        end else if (!expired) begin
          slc_wdata = slc_rdata_q - 8'd1;
        end else begin
          head_pop = 1'b1;
          if (32'(lv_q) + 1 < used_n && next_room)
            tgt_d = lv_q + LW'(1);
          state_d = mlfq_pkg::StPush;
        end
        out_d.level_after = 2'(tgt_d);
      end
      mlfq_pkg::StPush: begin
        // The head was popped already, so its own level always has room.
        tail_sum = (CW+1)'(head_q[tgt_q]) + (CW+1)'(count_q[tgt_q]);
        fifo_we = 1'b1;
        fifo_waddr = {tgt_q, slot_wrap(tail_sum)};
        proc_we = 1'b1;
        // The record read back still holds the work from before this tick.
        work_wdata = work_rdata_q - 16'd1;
        slc_wdata = slice_of(tgt_q, slice_q[0], slice_q[1], slice_q[2], slice_q[3]);
        push_lv = tgt_q;
        tail_push = 1'b1;
        out_d.level_after = 2'(tgt_q);
        state_d = mlfq_pkg::StOut;
      end
      mlfq_pkg::StOut: begin
        state_d = mlfq_pkg::StIdle;
      end
      default: state_d = mlfq_pkg::StIdle;
    endcase
    push_en = tail_push;
  end

  // Sequencer state, queue pointers, start flags and time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlfq_pkg::StIdle;
      out_valid_q <= 1'b0;
      started_q <= '0;
      now_q <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == mlfq_pkg::StOut) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (time_step) now_q <= now_q + 24'd1;
      if (start_set) started_q[pid_q] <= 1'b1;
      if (accept && in_data_i.kind == mlfq_pkg::KindArrive && tail_push)
        started_q[arr_pid] <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (head_pop && LW'(i) == lv_q) begin
          head_q[i] <= (32'(head_q[i]) + 1 >= MAX_PROCS) ? '0 : head_q[i] + PW'(1);
        end
        if (push_en && LW'(i) == push_lv && !(head_pop && LW'(i) == lv_q))
          count_q[i] <= count_q[i] + CW'(1);
        else if (head_pop && LW'(i) == lv_q && !(push_en && LW'(i) == push_lv))
          count_q[i] <= count_q[i] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    lv_q  <= lv_d;
    tgt_q <= tgt_d;
    pid_q <= pid_d;
  end

`ifndef NO_ASSERTIONS
  // No new beat is taken while an item is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mlfq_pkg::StIdle) |-> !accept) else $error("accept while busy");
  // A tick that runs a process always passes through the process stage.
  a_read_to_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlfq_pkg::StRead) |=> (state_q == mlfq_pkg::StProc))
    else $error("sequencer skipped process stage");
  // A result is raised exactly after the output stage.
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlfq_pkg::StOut) |=> out_valid_o) else $error("result lost");
`endif

endmodule

FILE: tb/sv/multilevel_feedback_queue_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback queue scheduler testbench
// Drives arrivals and ticks through the valid/stall channels with random idling
// on both sides, and checks every result beat against a behavioral scheduler.
// ----------------------------------------------------------------------------

// Behavioral scheduler and store of expected result beats.
class mlfq_scoreboard;
  logic [2:0]  levels_used;
  logic [7:0]  slice_reg [4];
  logic [3:0]  queue_id [4][16];
  int unsigned queue_head [4];
  int unsigned queue_count [4];
  logic [15:0] work_left [16];
  logic [7:0]  slice_rem [16];
  bit          started [16];
  logic [23:0] now_ticks;
  mlfq_pkg::out_item_t pending_q[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned finishes_seen;
  int unsigned rejects_seen;

  function new();
    levels_used = 3'd4;
    slice_reg[0] = 8'd1;
    slice_reg[1] = 8'd2;
    slice_reg[2] = 8'd4;
    slice_reg[3] = 8'd8;
    for (int l = 0; l < 4; l++) begin
      queue_head[l] = 0;
      queue_count[l] = 0;
    end
    for (int p = 0; p < 16; p++) begin
      started[p] = 0;
      work_left[p] = '0;
      slice_rem[p] = '0;
    end
    now_ticks = '0;
    errors = 0;
    results_seen = 0;
    finishes_seen = 0;
    rejects_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [7:0] value);
    case (idx)
      mlfq_pkg::RegLevelsUsed: levels_used = value[2:0];
      mlfq_pkg::RegSlice0:     slice_reg[0] = value;
      mlfq_pkg::RegSlice1:     slice_reg[1] = value;
      mlfq_pkg::RegSlice2:     slice_reg[2] = value;
      mlfq_pkg::RegSlice3:     slice_reg[3] = value;
      default: ;
    endcase
  endfunction

  function bit enqueue(int unsigned lv, logic [3:0] pid);
    if (queue_count[lv] >= 16) return 0;
    queue_id[lv][(queue_head[lv] + queue_count[lv]) % 16] = pid;
    queue_count[lv]++;
    return 1;
  endfunction

  function int unsigned queue_depth(int unsigned lv);
    return queue_count[lv];
  endfunction

  // Notes one accepted input beat and queues its expected result.
  function void note_input(mlfq_pkg::in_item_t item);
    mlfq_pkg::out_item_t res;
    int unsigned lv, target, used;
    logic [3:0] pid;
    res = '0;
    if (item.kind == mlfq_pkg::KindArrive) begin
      pid = item.proc_id;
      if (!enqueue(0, pid)) begin
        res.rejected = 1'b1;
      end else begin
        work_left[pid] = item.work_time;
        slice_rem[pid] = slice_reg[0];
        started[pid] = 0;
      end
    end else begin
      lv = 0;
      while (lv < 4 && queue_count[lv] == 0) lv++;
      if (lv < 4) begin
        pid = queue_id[lv][queue_head[lv]];
        res.ran = 1'b1;
        res.ran_pid = pid;
        res.first_run = !started[pid];
        started[pid] = 1;
        target = lv;
        if (work_left[pid] <= 1) begin
          work_left[pid] = '0;
          queue_head[lv] = (queue_head[lv] + 1) % 16;
          queue_count[lv]--;
          res.finished = 1'b1;
          res.finish_time = now_ticks + 24'd1;
        end else begin
          work_left[pid] = work_left[pid] - 16'd1;
          if (slice_rem[pid] > 1) begin
            slice_rem[pid] = slice_rem[pid] - 8'd1;
          end else begin
            queue_head[lv] = (queue_head[lv] + 1) % 16;
            queue_count[lv]--;
            used = levels_used;
            if (used < 1) used = 1;
            if (used > 4) used = 4;
            if (lv + 1 < used) target = lv + 1;
            if (!enqueue(target, pid)) begin
              target = lv;
              void'(enqueue(lv, pid));
            end
            slice_rem[pid] = slice_reg[target];
          end
        end
        res.level_after = target[1:0];
      end
      now_ticks = now_ticks + 24'd1;
    end
    pending_q = {pending_q, res};
  endfunction

  // Compares one result beat with the oldest expectation.
  function void check_result(mlfq_pkg::out_item_t got);
    mlfq_pkg::out_item_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result beat %p", $time, got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    results_seen++;
    if (got.finished) finishes_seen++;
    if (got.rejected) rejects_seen++;
    if (got.ran !== want.ran || got.ran_pid !== want.ran_pid ||
        got.first_run !== want.first_run || got.finished !== want.finished ||
        got.finish_time !== want.finish_time ||
        got.level_after !== want.level_after || got.rejected !== want.rejected) begin
      $display("%0t: mismatch expected %p actual %p", $time, want, got);
      errors++;
    end
  endfunction
endclass

module multilevel_feedback_queue_scheduler_tb;

  localparam int unsigned IdleLimit = 5000;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [2:0] RegUnused = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  mlfq_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  mlfq_pkg::out_item_t out_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  int unsigned beats_sent;
  mlfq_scoreboard sched_model;

  multilevel_feedback_queue_scheduler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: random stall, result check on each accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sched_model.check_result(out_data);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no accepted beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("watchdog expired at %0t", $time);
        $display("** multilevel_feedback_queue_scheduler: FAILED **");
        $finish;
      end
    end
  end

  // Sends one beat, with optional idle cycles ahead of it.
  task automatic send_beat(mlfq_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sched_model.note_input(item);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_arrival(logic [3:0] pid, logic [15:0] work);
    mlfq_pkg::in_item_t item;
    item.kind = mlfq_pkg::KindArrive;
    item.proc_id = pid;
    item.work_time = work;
    send_beat(item);
  endtask

  task automatic send_tick();
    mlfq_pkg::in_item_t item;
    item.kind = mlfq_pkg::KindTick;
    item.proc_id = 4'($urandom);
    item.work_time = 16'($urandom);
    send_beat(item);
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sched_model.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sched_model.write_reg(idx, value);
  endtask

  // One random phase: mostly short work, occasional zero-work and long jobs.
  task automatic random_phase(int unsigned count);
    logic [15:0] work;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 40 && sched_model.queue_depth(0) < 17) begin
        case ($urandom_range(9))
          0:       work = 16'($urandom);
          1:       work = 16'd0;
          2:       work = 16'hFFFF;
          default: work = 16'($urandom_range(1, 12));
        endcase
        send_arrival(4'($urandom), work);
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    sched_model = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 70;
    quiet_cycles = 0;
    beats_sent = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: idle tick, zero and maximum work, repeated id, first run.
    send_tick();
    send_arrival(4'd0, 16'd0);
    send_arrival(4'd15, 16'hFFFF);
    send_arrival(4'd5, 16'd3);
    send_arrival(4'd5, 16'd2);
    repeat (8) send_tick();
    // Fill level 0 past its depth so arrivals get rejected.
    for (int i = 0; i < 18; i++) send_arrival(4'(i), 16'd1);
    repeat (4) send_tick();
    drain();

    // Single level, extreme slices, and a process left beyond levels_used.
    write_reg(mlfq_pkg::RegLevelsUsed, 8'd1);
    write_reg(mlfq_pkg::RegSlice0, 8'd255);
    write_reg(mlfq_pkg::RegSlice1, 8'd0);
    write_reg(mlfq_pkg::RegSlice2, 8'd255);
    write_reg(mlfq_pkg::RegSlice3, 8'd1);
    random_phase(200);
    drain();
    write_reg(mlfq_pkg::RegLevelsUsed, 8'd7);
    write_reg(mlfq_pkg::RegSlice0, 8'd1);
    write_reg(RegUnused, 8'hA5);
    random_phase(250);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 27;
    write_reg(mlfq_pkg::RegLevelsUsed, 8'd0);
    write_reg(mlfq_pkg::RegSlice0, 8'd0);
    random_phase(200);
    drain();
    write_reg(mlfq_pkg::RegLevelsUsed, 8'd4);
    write_reg(mlfq_pkg::RegSlice0, 8'd2);
    write_reg(mlfq_pkg::RegSlice1, 8'd3);
    write_reg(mlfq_pkg::RegSlice2, 8'd5);
    write_reg(mlfq_pkg::RegSlice3, 8'd255);
    random_phase(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(mlfq_pkg::RegLevelsUsed, 8'd3);
    write_reg(mlfq_pkg::RegSlice3, 8'd0);
    random_phase(380);
    drain();

    $display("Sent %0d beats, checked %0d results (%0d completions, %0d rejections).",
             beats_sent, sched_model.results_seen, sched_model.finishes_seen,
             sched_model.rejects_seen);
    $display("Covered several slice and level settings under three idling patterns.");
    if (sched_model.errors == 0 && sched_model.pending_q.size() == 0) begin
      $display("** multilevel_feedback_queue_scheduler: PASSED **");
    end else begin
      $display("** multilevel_feedback_queue_scheduler: FAILED **");
    end
    $finish;
  end
endmodule
